@@ rtl/mtcg_pkg.sv @@
// ---------------------------------------------------------------------------
// mtcg_pkg
// Types and constants shared by the MIDI to CV/gate parser modules.
// ---------------------------------------------------------------------------
package mtcg_pkg;

    localparam int BYTE_W   = 8;
    localparam int NOTE_W   = 7;
    localparam int DAC_W    = 12;
    localparam int BURST_N  = 3;
    localparam int CNT_W    = 2;

    localparam logic [BYTE_W-1:0] STATUS_LIMIT = 8'hF0;
    localparam logic [BYTE_W-1:0] RT_CLOCK     = 8'hF8;
    localparam logic [BYTE_W-1:0] RT_START     = 8'hFA;
    localparam logic [BYTE_W-1:0] RT_STOP      = 8'hFC;
    localparam logic [BYTE_W-1:0] RT_RESET     = 8'hFF;

    localparam logic [BYTE_W-1:0] GATE_NOTE  = 8'h01;
    localparam logic [BYTE_W-1:0] GATE_RESET = 8'h20;
    localparam logic [BYTE_W-1:0] GATE_RUN   = 8'h40;
    localparam logic [BYTE_W-1:0] GATE_CLOCK = 8'h80;

    localparam logic DAC_CH_NOTE  = 1'b0;
    localparam logic DAC_CH_WHEEL = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_NOTE_ON  = 3'd2,
        KIND_KEY_PRES = 3'd3,
        KIND_CTRL     = 3'd4,
        KIND_PROG     = 3'd5,
        KIND_CH_PRES  = 3'd6,
        KIND_WHEEL    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] gate_bits;
        logic              dac_write;
        logic              dac_channel;
        logic [DAC_W-1:0]  dac_value;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        res_t [BURST_N-1:0]   r;
    } burst_t;

endpackage

@@ rtl/midi_to_cv_gate_parser.sv @@
// ---------------------------------------------------------------------------
// midi_to_cv_gate_parser
// MIDI byte stream to note gate, clock/run/reset bits and DAC writes.
// ---------------------------------------------------------------------------
// usage
//   input channel: one MIDI byte per beat on midi_byte, in_valid / in_stall
//   output channel: one result per beat (gate_bits, dac_write, dac_channel,
//   dac_value, last), out_valid / out_stall; last marks the final result of
//   a byte, bytes that cause nothing give no beat
//   path: input register, burst register, then output register
//   throughput: one byte per cycle while out_stall is low and each byte
//   gives at most one result; a byte that gives k results (at most 3)
//   holds the burst register until the single output register drains it
//   reset: running status, data phase, notes, wheel low byte and gate
//   register clear; no beat is pending on either side
//   stall: out_stall holds the output beat; the burst register and the
//   input register then fill and in_stall rises, no byte is dropped
// ---------------------------------------------------------------------------
module midi_to_cv_gate_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mtcg_pkg::BYTE_W-1:0]   midi_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mtcg_pkg::BYTE_W-1:0]   gate_bits,
    output logic                          dac_write,
    output logic                          dac_channel,
    output logic [mtcg_pkg::DAC_W-1:0]    dac_value,
    output logic                          last
);

    logic                          in_valid_reg;
    logic [mtcg_pkg::BYTE_W-1:0]   in_byte_reg;
    mtcg_pkg::burst_t              dec_burst;
    mtcg_pkg::burst_t              burst_reg, burst_next;
    logic                          out_valid_reg, out_valid_next;
    mtcg_pkg::res_t                out_reg;
    logic                          out_load;
    logic                          burst_free;
    logic                          process;
    logic                          in_take;

    assign out_load   = (burst_reg.cnt != '0) && (!out_valid_reg || !out_stall);
    assign burst_free = (burst_reg.cnt == '0) || ((burst_reg.cnt == 2'd1) && out_load);
    assign process    = in_valid_reg && burst_free;
    assign in_stall   = in_valid_reg && !process;
    assign in_take    = in_valid && !in_stall;

    mtcg_decode u_decode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (process),
        .data  (in_byte_reg),
        .burst (dec_burst)
    );

    always_comb
    begin
        burst_next = burst_reg;
        if (process)
        begin
            burst_next = dec_burst;
        end
        else if (out_load)
        begin
            burst_next.r[0] = burst_reg.r[1];
            burst_next.r[1] = burst_reg.r[2];
            burst_next.r[2] = '0;
            burst_next.cnt  = burst_reg.cnt - 2'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;
            burst_reg     <= burst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= midi_byte;
        if (out_load)
            out_reg <= burst_reg.r[0];
    end

    assign out_valid   = out_valid_reg;
    assign gate_bits   = out_reg.gate_bits;
    assign dac_write   = out_reg.dac_write;
    assign dac_channel = out_reg.dac_channel;
    assign dac_value   = out_reg.dac_value;
    assign last        = out_reg.last;

    // final entry of a pending burst closes its byte
    a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_reg.cnt != '0) |-> burst_reg.r[burst_reg.cnt - 2'd1].last)
        else $error("burst without closing entry");

    // a held input byte stays until it is decoded
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !process) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost while waiting");

    // a loaded entry always reaches the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    // beats without a dac write carry zero dac fields
    a_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.dac_write)
            |-> (out_reg.dac_value == '0 && out_reg.dac_channel == 1'b0))
        else $error("dac fields set without dac write");

endmodule

@@ rtl/mtcg_decode.sv @@
// ---------------------------------------------------------------------------
// mtcg_decode
// MIDI message state and decode of one byte into a burst of up to three
// results; state advances when fire is high.
// ---------------------------------------------------------------------------
module mtcg_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [mtcg_pkg::BYTE_W-1:0]   data,
    output mtcg_pkg::burst_t              burst
);

    mtcg_pkg::kind_t                  kind_reg, kind_next;
    mtcg_pkg::phase_t                 phase_reg, phase_next;
    logic [mtcg_pkg::NOTE_W-1:0]      pend_reg, pend_next;
    logic [mtcg_pkg::NOTE_W-1:0]      held_reg, held_next;
    logic [mtcg_pkg::NOTE_W-1:0]      wlow_reg, wlow_next;
    logic [mtcg_pkg::BYTE_W-1:0]      gate_reg, gate_next;
    logic [2*mtcg_pkg::NOTE_W-1:0]    wheel_full;

    assign wheel_full = {data[mtcg_pkg::NOTE_W-1:0], wlow_reg};

    always_comb
    begin
        kind_next  = kind_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        held_next  = held_reg;
        wlow_next  = wlow_reg;
        gate_next  = gate_reg;
        burst      = '0;

        if (data[mtcg_pkg::BYTE_W-1])
        begin
            if (data < mtcg_pkg::STATUS_LIMIT)
            begin
                kind_next  = mtcg_pkg::kind_t'(data[6:4] + 3'd1);
                phase_next = mtcg_pkg::PH_FIRST;
            end
            else
            begin
                case (data)
                    mtcg_pkg::RT_CLOCK: gate_next = gate_reg ^ mtcg_pkg::GATE_CLOCK;
                    mtcg_pkg::RT_START: gate_next = (gate_reg | mtcg_pkg::GATE_RUN)
                                                    & ~mtcg_pkg::GATE_RESET;
                    mtcg_pkg::RT_STOP:  gate_next = gate_reg & ~mtcg_pkg::GATE_RUN;
                    mtcg_pkg::RT_RESET: gate_next = (gate_reg & ~mtcg_pkg::GATE_RUN)
                                                    | mtcg_pkg::GATE_RESET;
                    default:            gate_next = gate_reg;
                endcase
                if (data inside {mtcg_pkg::RT_CLOCK, mtcg_pkg::RT_START,
                                 mtcg_pkg::RT_STOP, mtcg_pkg::RT_RESET})
                begin
                    burst.cnt            = 2'd1;
                    burst.r[0].gate_bits = gate_next;
                    burst.r[0].last      = 1'b1;
                end
            end
        end
        else if ((phase_reg inside {mtcg_pkg::PH_FIRST, mtcg_pkg::PH_SECOND})
                 && !(kind_reg inside {mtcg_pkg::KIND_NONE, mtcg_pkg::KIND_PROG,
                                       mtcg_pkg::KIND_CH_PRES}))
        begin
            if (phase_reg == mtcg_pkg::PH_FIRST)
            begin
                if (kind_reg == mtcg_pkg::KIND_WHEEL)
                    wlow_next = data[mtcg_pkg::NOTE_W-1:0];
                else
                    pend_next = data[mtcg_pkg::NOTE_W-1:0];
                phase_next = mtcg_pkg::PH_SECOND;
            end
            else
            begin
                phase_next = mtcg_pkg::PH_FIRST;
                case (kind_reg)
                    mtcg_pkg::KIND_NOTE_OFF:
                    begin
                        if (pend_reg == held_reg)
                        begin
                            gate_next            = gate_reg & ~mtcg_pkg::GATE_NOTE;
                            burst.cnt            = 2'd1;
                            burst.r[0].gate_bits = gate_next;
                            burst.r[0].last      = 1'b1;
                        end
                    end
                    mtcg_pkg::KIND_NOTE_ON:
                    begin
                        if (data != '0)
                        begin
                            held_next              = pend_reg;
                            gate_next              = gate_reg | mtcg_pkg::GATE_NOTE;
                            burst.r[0].gate_bits   = gate_reg;
                            burst.r[0].dac_write   = 1'b1;
                            burst.r[0].dac_channel = mtcg_pkg::DAC_CH_NOTE;
                            burst.r[0].dac_value   = {pend_reg, 5'd0};
                            if (gate_reg[0])
                            begin
                                burst.cnt            = 2'd3;
                                burst.r[1].gate_bits = gate_reg & ~mtcg_pkg::GATE_NOTE;
                                burst.r[2].gate_bits = gate_next;
                                burst.r[2].last      = 1'b1;
                            end
                            else
                            begin
                                burst.cnt            = 2'd2;
                                burst.r[1].gate_bits = gate_next;
                                burst.r[1].last      = 1'b1;
                            end
                        end
                        else
                        begin
                            if (pend_reg == held_reg)
                                gate_next = gate_reg & ~mtcg_pkg::GATE_NOTE;
                            burst.cnt            = 2'd1;
                            burst.r[0].gate_bits = gate_next;
                            burst.r[0].last      = 1'b1;
                        end
                    end
                    mtcg_pkg::KIND_WHEEL:
                    begin
                        burst.cnt              = 2'd1;
                        burst.r[0].gate_bits   = gate_reg;
                        burst.r[0].dac_write   = 1'b1;
                        burst.r[0].dac_channel = mtcg_pkg::DAC_CH_WHEEL;
                        burst.r[0].dac_value   = wheel_full[2*mtcg_pkg::NOTE_W-1:2];
                        burst.r[0].last        = 1'b1;
                    end
                    default:
                    begin
                        burst.cnt = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= mtcg_pkg::KIND_NONE;
            phase_reg <= mtcg_pkg::PH_IDLE;
            pend_reg  <= '0;
            held_reg  <= '0;
            wlow_reg  <= '0;
            gate_reg  <= '0;
        end
        else if (fire)
        begin
            kind_reg  <= kind_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            wlow_reg  <= wlow_next;
            gate_reg  <= gate_next;
        end
    end

endmodule

@@ sim/midi_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi_result_checker
// Watches both channels of the MIDI to CV/gate parser. Every accepted MIDI
// byte runs through a cycle-free model of the parser state (running status,
// data phase, notes, wheel low byte, gate register), which queues the result
// beats the byte must cause. Each accepted output beat is compared with the
// oldest queued beat. Failures are counted and handed to the testbench top.
// ---------------------------------------------------------------------------
module midi_result_checker
    import mtcg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [BYTE_W-1:0]   midi_byte,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [BYTE_W-1:0]   gate_bits,
    input  logic                dac_write,
    input  logic                dac_channel,
    input  logic [DAC_W-1:0]    dac_value,
    input  logic                last,
    output int                  fail_count,
    output int                  pending_results,
    output int                  results_checked,
    output int                  dac_writes_seen
);

    localparam int MAX_REPORTS = 10;

    kind_t              run_kind;
    phase_t             run_phase;
    logic [NOTE_W-1:0]  pending_note_q;
    logic [NOTE_W-1:0]  held_note_q;
    logic [NOTE_W-1:0]  wheel_lo_q;
    logic [BYTE_W-1:0]  gate_q;
    res_t               expected_results [$];
    res_t               got;
    res_t               want;

    function automatic res_t make_beat(input logic [BYTE_W-1:0] g, input logic dw,
                                       input logic ch, input logic [DAC_W-1:0] v,
                                       input logic fin);
        res_t r;
        r.gate_bits   = g;
        r.dac_write   = dw;
        r.dac_channel = ch;
        r.dac_value   = v;
        r.last        = fin;
        return r;
    endfunction

    task automatic predict_midi_byte(input logic [BYTE_W-1:0] b);
        res_t              burst [BURST_N];
        int                n;
        logic [13:0]       wheel_full;
        n = 0;
        if (b[7])
        begin
            if (b < STATUS_LIMIT)
            begin
                run_kind  = kind_t'(b[6:4] + 3'd1);
                run_phase = PH_FIRST;
            end
            else if (b inside {RT_CLOCK, RT_START, RT_STOP, RT_RESET})
            begin
                case (b)
                    RT_CLOCK: gate_q = gate_q ^ GATE_CLOCK;
                    RT_START: gate_q = (gate_q | GATE_RUN) & ~GATE_RESET;
                    RT_STOP:  gate_q = gate_q & ~GATE_RUN;
                    default:  gate_q = (gate_q & ~GATE_RUN) | GATE_RESET;
                endcase
                burst[n] = make_beat(gate_q, 1'b0, 1'b0, '0, 1'b0);
                n = n + 1;
            end
        end
        else if ((run_phase inside {PH_FIRST, PH_SECOND})
                 && !(run_kind inside {KIND_NONE, KIND_PROG, KIND_CH_PRES}))
        begin
            if (run_phase == PH_FIRST)
            begin
                if (run_kind == KIND_WHEEL)
                    wheel_lo_q = b[NOTE_W-1:0];
                else
                    pending_note_q = b[NOTE_W-1:0];
                run_phase = PH_SECOND;
            end
            else
            begin
                run_phase = PH_FIRST;
                case (run_kind)
                    KIND_NOTE_OFF:
                    begin
                        if (pending_note_q == held_note_q)
                        begin
                            gate_q   = gate_q & ~GATE_NOTE;
                            burst[n] = make_beat(gate_q, 1'b0, 1'b0, '0, 1'b0);
                            n = n + 1;
                        end
                    end
                    KIND_NOTE_ON:
                    begin
                        if (b != '0)
                        begin
                            held_note_q = pending_note_q;
                            burst[n] = make_beat(gate_q, 1'b1, DAC_CH_NOTE,
                                                 {held_note_q, 5'b0}, 1'b0);
                            n = n + 1;
                            if (gate_q[0])
                            begin
                                gate_q   = gate_q & ~GATE_NOTE;
                                burst[n] = make_beat(gate_q, 1'b0, 1'b0, '0, 1'b0);
                                n = n + 1;
                            end
                            gate_q   = gate_q | GATE_NOTE;
                            burst[n] = make_beat(gate_q, 1'b0, 1'b0, '0, 1'b0);
                            n = n + 1;
                        end
                        else
                        begin
                            if (pending_note_q == held_note_q)
                                gate_q = gate_q & ~GATE_NOTE;
                            burst[n] = make_beat(gate_q, 1'b0, 1'b0, '0, 1'b0);
                            n = n + 1;
                        end
                    end
                    KIND_WHEEL:
                    begin
                        wheel_full = {b[NOTE_W-1:0], wheel_lo_q};
                        burst[n]   = make_beat(gate_q, 1'b1, DAC_CH_WHEEL,
                                               wheel_full[13:2], 1'b0);
                        n = n + 1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (n > 0)
            burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(burst[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind        = KIND_NONE;
            run_phase       = PH_IDLE;
            pending_note_q  = '0;
            held_note_q     = '0;
            wheel_lo_q      = '0;
            gate_q          = '0;
            expected_results.delete();
            fail_count      = 0;
            pending_results = 0;
            results_checked = 0;
            dac_writes_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_midi_byte(midi_byte);
            if (out_valid && !out_stall)
            begin
                got = make_beat(gate_bits, dac_write, dac_channel, dac_value, last);
                results_checked = results_checked + 1;
                if (dac_write === 1'b1)
                    dac_writes_seen = dac_writes_seen + 1;
                if (expected_results.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result beat with none expected: gate %h dac %b/%b/%h %b",
                                 $realtime, got.gate_bits, got.dac_write, got.dac_channel,
                                 got.dac_value, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.gate_bits !== want.gate_bits || got.dac_write !== want.dac_write
                        || got.dac_channel !== want.dac_channel
                        || got.dac_value !== want.dac_value || got.last !== want.last)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected gate %h dac %b/%b/%h last %b",
                                     want.gate_bits, want.dac_write, want.dac_channel,
                                     want.dac_value, want.last);
                            $display("  actual   gate %h dac %b/%b/%h last %b",
                                     got.gate_bits, got.dac_write, got.dac_channel,
                                     got.dac_value, got.last);
                        end
                    end
                end
            end
            pending_results = expected_results.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench top for midi_to_cv_gate_parser. Feeds a short directed byte
// sequence (realtime bytes, note-on with retrigger, velocity-zero note-on,
// note-off, pitch wheel at full scale, one-byte messages, a status cut into a
// message) and then random MIDI traffic, mostly well-formed messages under
// running status with noise and broken messages mixed in. Sender and
// receiver idle at random in three patterns. The checker beside the block
// predicts and compares every result beat; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;
    import mtcg_pkg::*;

    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int SETTLE_CYCLES    = 10;

    localparam logic [BYTE_W-1:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [BYTE_W-1:0] ST_NOTE_ON   = 8'h90;
    localparam logic [BYTE_W-1:0] ST_KEY_PRES  = 8'hA0;
    localparam logic [BYTE_W-1:0] ST_CTRL      = 8'hB0;
    localparam logic [BYTE_W-1:0] ST_PROG      = 8'hC0;
    localparam logic [BYTE_W-1:0] ST_CH_PRES   = 8'hD0;
    localparam logic [BYTE_W-1:0] ST_WHEEL     = 8'hE0;
    localparam logic [BYTE_W-1:0] RT_UNDEFINED = 8'hF9;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  midi_byte;
    logic               out_valid;
    logic               out_stall;
    logic [BYTE_W-1:0]  gate_bits;
    logic               dac_write;
    logic               dac_channel;
    logic [DAC_W-1:0]   dac_value;
    logic               last;

    int                 fail_count;
    int                 pending_results;
    int                 results_checked;
    int                 dac_writes_seen;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 bytes_sent;
    int                 quiet_cycles;
    int                 phase_start;
    bit                 paused_once;
    logic [BYTE_W-1:0]  last_status;

    midi_to_cv_gate_parser uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .midi_byte   (midi_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .gate_bits   (gate_bits),
        .dac_write   (dac_write),
        .dac_channel (dac_channel),
        .dac_value   (dac_value),
        .last        (last)
    );

    midi_result_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .midi_byte       (midi_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .gate_bits       (gate_bits),
        .dac_write       (dac_write),
        .dac_channel     (dac_channel),
        .dac_value       (dac_value),
        .last            (last),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .dac_writes_seen (dac_writes_seen)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
    end

    // no beat accepted on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        midi_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // data byte, now and then preceded by a realtime byte inside the message
    task automatic send_data(input logic [BYTE_W-1:0] b);
        if ($urandom_range(19) == 0)
            send_byte(RT_CLOCK + BYTE_W'($urandom_range(7)));
        send_byte(b);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_note();
        if ($urandom_range(3) != 0)
            return 8'd60 + BYTE_W'($urandom_range(2));
        return BYTE_W'($urandom_range(127));
    endfunction

    task automatic send_status(input logic [BYTE_W-1:0] st);
        if (st[7:4] == last_status[7:4] && $urandom_range(1) == 1)
            return;
        send_byte(st);
        last_status = st;
    endtask

    task automatic send_random_message();
        int                 pick;
        logic [BYTE_W-1:0]  st;
        pick = int'($urandom_range(99));
        st   = BYTE_W'($urandom_range(15));
        if (pick < 8)
        begin
            send_byte(BYTE_W'($urandom_range(255)));
            last_status = '0;
        end
        else if (pick < 18)
        begin
            send_byte(RT_CLOCK + BYTE_W'($urandom_range(7)));
        end
        else if (pick < 23)
        begin
            // message cut short, the next one needs a fresh status
            send_byte(ST_NOTE_OFF + BYTE_W'($urandom_range(6) << 4) + st);
            send_byte(pick_note());
            last_status = '0;
        end
        else if (pick < 55)
        begin
            send_status(ST_NOTE_ON | st);
            send_data(pick_note());
            send_data(($urandom_range(3) == 0) ? 8'h00 : BYTE_W'($urandom_range(127, 1)));
        end
        else if (pick < 70)
        begin
            send_status(ST_NOTE_OFF | st);
            send_data(pick_note());
            send_data(BYTE_W'($urandom_range(127)));
        end
        else if (pick < 82)
        begin
            send_status(ST_WHEEL | st);
            send_data(BYTE_W'($urandom_range(127)));
            send_data(BYTE_W'($urandom_range(127)));
        end
        else if (pick < 93)
        begin
            send_status(((pick < 88) ? ST_KEY_PRES : ST_CTRL) | st);
            send_data(BYTE_W'($urandom_range(127)));
            send_data(BYTE_W'($urandom_range(127)));
        end
        else
        begin
            send_status(((pick < 96) ? ST_PROG : ST_CH_PRES) | st);
            send_data(BYTE_W'($urandom_range(127)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        midi_byte     = '0;
        bytes_sent    = 0;
        paused_once   = 1'b0;
        last_status   = '0;
        send_idle_pct = 32;
        recv_idle_pct = 64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data with no status, then realtime bytes
        send_byte(8'h45);
        send_byte(RT_CLOCK);
        send_byte(RT_START);
        send_byte(RT_RESET);
        send_byte(RT_STOP);
        send_byte(RT_UNDEFINED);
        // note-on, then retrigger of a held gate at the top note
        send_byte(ST_NOTE_ON);
        send_byte(8'h3C);
        send_byte(8'h64);
        send_byte(8'h7F);
        send_byte(8'h7F);
        // velocity zero for another note with a clock inside, then for the held note
        send_byte(8'h3C);
        send_byte(RT_CLOCK);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h00);
        // note-off of the held note on the last channel
        send_byte(ST_NOTE_OFF | 8'h0F);
        send_byte(8'h7F);
        send_byte(8'h40);
        // pitch wheel at full scale, program change, status cutting a message
        send_byte(ST_WHEEL | 8'h0F);
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte(ST_PROG | 8'h03);
        send_byte(8'h55);
        send_byte(ST_NOTE_ON);
        send_byte(8'h10);
        send_byte(ST_CTRL);
        send_byte(8'h01);
        send_byte(8'h02);
        wait_results_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_PER_PHASE)
            begin
                send_random_message();
                if (!paused_once && bytes_sent - phase_start >= RANDOM_PER_PHASE / 2)
                begin
                    wait_results_drained();
                    paused_once = 1'b1;
                end
            end
            wait_results_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d MIDI bytes: directed cases, then random traffic",
                 bytes_sent);
        $display("under three idle patterns; %0d result beats checked, %0d with a DAC write",
                 results_checked, dac_writes_seen);
        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
